// ===== src/cap_pkg.sv =====
package cap_pkg;

    localparam int FRAC_BITS = 16;

    localparam int IN_W   = 32;
    localparam int D_W    = IN_W + 1;
    localparam int P_W    = 64;
    localparam int DOT_W  = 66;
    localparam int DM_W   = 65;
    localparam int VV_W   = 64;
    localparam int C_W    = 65;
    localparam int CA_W   = 64;
    localparam int HALF_W = CA_W / 2;
    localparam int SQ_W   = 2 * CA_W;
    localparam int CSQ_W  = SQ_W + 2;
    localparam int OUT_W  = 31;
    localparam int QM_W   = 2 * OUT_W;
    localparam int QT_W   = OUT_W;
    localparam int QR_W   = OUT_W;
    localparam int SR_W   = OUT_W + 2;
    localparam int TGT_W  = DM_W + FRAC_BITS;
    localparam int TH_W   = TGT_W - QT_W;
    localparam int CH_W   = CSQ_W - QM_W;
    localparam int FRONT  = 8;
    localparam int NST    = FRONT + QM_W + QR_W;
    localparam int S_DW   = 9 * IN_W;
    localparam int M_DW   = 64;

    localparam logic [OUT_W-1:0] SAT_VAL = '1;

endpackage

// ===== src/closest_approach_predictor.sv =====
// Closest point of approach predictor. Each transfer on the slave side carries own position,
// other position and own velocity (signed Q16.16); each master-side transfer carries the
// approaching flag, the perpendicular miss distance and the time to closest approach,
// both floored and saturated to 2^31-1, which also stands for "never" when approaching is 0.
// One item is accepted per clock while the master side keeps up. The pipeline has eight
// arithmetic stages, a 62-stage restoring divider (one quotient bit per stage) that runs
// beside a 31-stage divider for the time, and a 31-stage square root, ahead of the output
// register. The whole pipeline holds while its last result waits in the skid register.
module closest_approach_predictor (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // own_x, own_y, own_z, other_x, other_y, other_z, vel_x, vel_y, vel_z
    input  logic [cap_pkg::S_DW-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // approaching, miss_distance, time_to_closest, one zero pad bit
    output logic [cap_pkg::M_DW-1:0]  m_tdata
);

    localparam int IW = cap_pkg::IN_W;

    logic en;
    logic [cap_pkg::NST-1:0] vld_reg;

    // Stage 1
    logic signed [cap_pkg::D_W-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [IW-1:0] vx_reg, vy_reg, vz_reg;
    // Stage 2
    logic signed [cap_pkg::P_W-1:0] p_reg [0:8];
    logic [cap_pkg::VV_W-1:0] s2_reg [0:2];
    // Stage 3
    logic signed [cap_pkg::DOT_W-1:0] dot_reg;
    logic [cap_pkg::VV_W-1:0] vv3_reg;
    logic signed [cap_pkg::C_W-1:0] c_reg [0:2];
    // Stage 4
    logic ap4_reg;
    logic [cap_pkg::DM_W-1:0] dm4_reg;
    logic [cap_pkg::VV_W-1:0] vv4_reg;
    logic [cap_pkg::CA_W-1:0] ca_reg [0:2];
    // Stage 5
    logic ap5_reg;
    logic [cap_pkg::DM_W-1:0] dm5_reg;
    logic [cap_pkg::VV_W-1:0] vv5_reg;
    logic [cap_pkg::CA_W-1:0] hh_reg [0:2];
    logic [cap_pkg::CA_W-1:0] hl_reg [0:2];
    logic [cap_pkg::CA_W-1:0] ll_reg [0:2];
    // Stage 6
    logic ap6_reg;
    logic [cap_pkg::DM_W-1:0] dm6_reg;
    logic [cap_pkg::VV_W-1:0] vv6_reg;
    logic [cap_pkg::SQ_W-1:0] sq_reg [0:2];
    // Stage 7
    logic ap7_reg;
    logic [cap_pkg::DM_W-1:0] dm7_reg;
    logic [cap_pkg::VV_W-1:0] vv7_reg;
    logic [cap_pkg::CSQ_W-1:0] csq_reg;

    // Divider stages, index 0 is the setup stage
    logic [cap_pkg::VV_W-1:0] mr_reg [0:cap_pkg::QM_W];
    logic [cap_pkg::QM_W-1:0] ml_reg [0:cap_pkg::QM_W];
    logic [cap_pkg::QM_W-1:0] mq_reg [0:cap_pkg::QM_W];
    logic [cap_pkg::VV_W-1:0] tr_reg [0:cap_pkg::QM_W];
    logic [cap_pkg::QT_W-1:0] tl_reg [0:cap_pkg::QM_W];
    logic [cap_pkg::QT_W-1:0] tq_reg [0:cap_pkg::QM_W];
    logic [cap_pkg::VV_W-1:0] vvd_reg [0:cap_pkg::QM_W];
    logic ap_reg [0:cap_pkg::QM_W];
    logic ms_reg [0:cap_pkg::QM_W];
    logic ts_reg [0:cap_pkg::QM_W];

    // Square root stages
    logic [cap_pkg::SR_W-1:0] sr_reg [0:cap_pkg::QR_W-1];
    logic [cap_pkg::QR_W-1:0] sroot_reg [0:cap_pkg::QR_W-1];
    logic [cap_pkg::QM_W-1:0] srad_reg [0:cap_pkg::QR_W-1];
    logic [cap_pkg::QT_W-1:0] stq_reg [0:cap_pkg::QR_W-1];
    logic sap_reg [0:cap_pkg::QR_W-1];
    logic sms_reg [0:cap_pkg::QR_W-1];
    logic sts_reg [0:cap_pkg::QR_W-1];

    logic out_vld_reg, skid_vld_reg;
    logic [cap_pkg::M_DW-1:0] out_reg, skid_reg;
    logic [cap_pkg::M_DW-1:0] res_next;

    logic [cap_pkg::TGT_W-1:0] tgt_next;
    logic [cap_pkg::TH_W-1:0] tgt_hi_next;
    logic [cap_pkg::CH_W-1:0] csq_hi_next;

    assign en       = !skid_vld_reg;
    assign s_tready = en;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[cap_pkg::NST-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg <= $signed({s_tdata[4*IW-1], s_tdata[4*IW-1:3*IW]})
                    - $signed({s_tdata[IW-1], s_tdata[IW-1:0]});
            dy_reg <= $signed({s_tdata[5*IW-1], s_tdata[5*IW-1:4*IW]})
                    - $signed({s_tdata[2*IW-1], s_tdata[2*IW-1:IW]});
            dz_reg <= $signed({s_tdata[6*IW-1], s_tdata[6*IW-1:5*IW]})
                    - $signed({s_tdata[3*IW-1], s_tdata[3*IW-1:2*IW]});
            vx_reg <= $signed(s_tdata[7*IW-1:6*IW]);
            vy_reg <= $signed(s_tdata[8*IW-1:7*IW]);
            vz_reg <= $signed(s_tdata[9*IW-1:8*IW]);
        end
    end

    function automatic logic signed [cap_pkg::P_W-1:0] smul(
        input logic signed [cap_pkg::D_W-1:0] a,
        input logic signed [IW-1:0] b
    );
        logic signed [cap_pkg::D_W+IW-1:0] p;
        p = a * $signed({b[IW-1], b});
        return p[cap_pkg::P_W-1:0];
    endfunction

    function automatic logic [cap_pkg::VV_W-1:0] vsq(input logic signed [IW-1:0] a);
        logic signed [2*IW-1:0] p;
        p = a * a;
        return $unsigned(p);
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg[0] <= smul(dx_reg, vx_reg);
            p_reg[1] <= smul(dy_reg, vy_reg);
            p_reg[2] <= smul(dz_reg, vz_reg);
            p_reg[3] <= smul(dy_reg, vz_reg);
            p_reg[4] <= smul(dz_reg, vy_reg);
            p_reg[5] <= smul(dz_reg, vx_reg);
            p_reg[6] <= smul(dx_reg, vz_reg);
            p_reg[7] <= smul(dx_reg, vy_reg);
            p_reg[8] <= smul(dy_reg, vx_reg);
            s2_reg[0] <= vsq(vx_reg);
            s2_reg[1] <= vsq(vy_reg);
            s2_reg[2] <= vsq(vz_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dot_reg <= $signed({{2{p_reg[0][63]}}, p_reg[0]})
                     + $signed({{2{p_reg[1][63]}}, p_reg[1]})
                     + $signed({{2{p_reg[2][63]}}, p_reg[2]});
            vv3_reg <= s2_reg[0] + s2_reg[1] + s2_reg[2];
            c_reg[0] <= $signed({p_reg[3][63], p_reg[3]}) - $signed({p_reg[4][63], p_reg[4]});
            c_reg[1] <= $signed({p_reg[5][63], p_reg[5]}) - $signed({p_reg[6][63], p_reg[6]});
            c_reg[2] <= $signed({p_reg[7][63], p_reg[7]}) - $signed({p_reg[8][63], p_reg[8]});
        end
    end

    function automatic logic [cap_pkg::CA_W-1:0] cabs(input logic signed [cap_pkg::C_W-1:0] c);
        logic signed [cap_pkg::C_W-1:0] n;
        n = -c;
        return c[cap_pkg::C_W-1] ? n[cap_pkg::CA_W-1:0] : c[cap_pkg::CA_W-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            ap4_reg <= !dot_reg[cap_pkg::DOT_W-1] && (dot_reg != '0) && (vv3_reg != '0);
            dm4_reg <= dot_reg[cap_pkg::DM_W-1:0];
            vv4_reg <= vv3_reg;
            for (int k = 0; k < 3; k++) begin
                ca_reg[k] <= cabs(c_reg[k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ap5_reg <= ap4_reg;
            dm5_reg <= dm4_reg;
            vv5_reg <= vv4_reg;
            for (int k = 0; k < 3; k++) begin
                hh_reg[k] <= ca_reg[k][cap_pkg::CA_W-1:cap_pkg::HALF_W]
                           * ca_reg[k][cap_pkg::CA_W-1:cap_pkg::HALF_W];
                hl_reg[k] <= ca_reg[k][cap_pkg::CA_W-1:cap_pkg::HALF_W]
                           * ca_reg[k][cap_pkg::HALF_W-1:0];
                ll_reg[k] <= ca_reg[k][cap_pkg::HALF_W-1:0] * ca_reg[k][cap_pkg::HALF_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ap6_reg <= ap5_reg;
            dm6_reg <= dm5_reg;
            vv6_reg <= vv5_reg;
            for (int k = 0; k < 3; k++) begin
                sq_reg[k] <= {hh_reg[k], {cap_pkg::CA_W{1'b0}}}
                           + ({{cap_pkg::CA_W{1'b0}}, hl_reg[k]} << (cap_pkg::HALF_W + 1))
                           + {{cap_pkg::CA_W{1'b0}}, ll_reg[k]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ap7_reg <= ap6_reg;
            dm7_reg <= dm6_reg;
            vv7_reg <= vv6_reg;
            csq_reg <= {2'b00, sq_reg[0]} + {2'b00, sq_reg[1]} + {2'b00, sq_reg[2]};
        end
    end

    assign tgt_next    = {dm7_reg, {cap_pkg::FRAC_BITS{1'b0}}};
    assign tgt_hi_next = tgt_next[cap_pkg::TGT_W-1:cap_pkg::QT_W];
    assign csq_hi_next = csq_reg[cap_pkg::CSQ_W-1:cap_pkg::QM_W];

    always_ff @(posedge aclk) begin
        if (en) begin
            ap_reg[0]  <= ap7_reg;
            vvd_reg[0] <= vv7_reg;
            ms_reg[0]  <= csq_hi_next >= cap_pkg::CH_W'(vv7_reg);
            mr_reg[0]  <= csq_hi_next[cap_pkg::VV_W-1:0];
            ml_reg[0]  <= csq_reg[cap_pkg::QM_W-1:0];
            mq_reg[0]  <= '0;
            ts_reg[0]  <= cap_pkg::VV_W'(tgt_hi_next) >= vv7_reg;
            tr_reg[0]  <= cap_pkg::VV_W'(tgt_hi_next);
            tl_reg[0]  <= tgt_next[cap_pkg::QT_W-1:0];
            tq_reg[0]  <= '0;
        end
    end

    for (genvar k = 0; k < cap_pkg::QM_W; k++) begin : g_div
        logic [cap_pkg::VV_W:0] mtrial_next, mdiff_next;
        logic mbit_next;

        assign mtrial_next = {mr_reg[k], ml_reg[k][cap_pkg::QM_W-1]};
        assign mdiff_next  = mtrial_next - {1'b0, vvd_reg[k]};
        assign mbit_next   = mtrial_next >= {1'b0, vvd_reg[k]};

        always_ff @(posedge aclk) begin
            if (en) begin
                ap_reg[k+1]  <= ap_reg[k];
                ms_reg[k+1]  <= ms_reg[k];
                ts_reg[k+1]  <= ts_reg[k];
                vvd_reg[k+1] <= vvd_reg[k];
                mr_reg[k+1]  <= mbit_next ? mdiff_next[cap_pkg::VV_W-1:0]
                                          : mtrial_next[cap_pkg::VV_W-1:0];
                ml_reg[k+1]  <= {ml_reg[k][cap_pkg::QM_W-2:0], 1'b0};
                mq_reg[k+1]  <= {mq_reg[k][cap_pkg::QM_W-2:0], mbit_next};
            end
        end

        if (k < cap_pkg::QT_W) begin : g_t
            logic [cap_pkg::VV_W:0] ttrial_next, tdiff_next;
            logic tbit_next;

            assign ttrial_next = {tr_reg[k], tl_reg[k][cap_pkg::QT_W-1]};
            assign tdiff_next  = ttrial_next - {1'b0, vvd_reg[k]};
            assign tbit_next   = ttrial_next >= {1'b0, vvd_reg[k]};

            always_ff @(posedge aclk) begin
                if (en) begin
                    tr_reg[k+1] <= tbit_next ? tdiff_next[cap_pkg::VV_W-1:0]
                                             : ttrial_next[cap_pkg::VV_W-1:0];
                    tl_reg[k+1] <= {tl_reg[k][cap_pkg::QT_W-2:0], 1'b0};
                    tq_reg[k+1] <= {tq_reg[k][cap_pkg::QT_W-2:0], tbit_next};
                end
            end
        end else begin : g_tc
            always_ff @(posedge aclk) begin
                if (en) begin
                    tr_reg[k+1] <= tr_reg[k];
                    tl_reg[k+1] <= tl_reg[k];
                    tq_reg[k+1] <= tq_reg[k];
                end
            end
        end
    end

    for (genvar j = 0; j < cap_pkg::QR_W; j++) begin : g_sqrt
        logic [cap_pkg::SR_W-1:0] rin_next;
        logic [cap_pkg::QR_W-1:0] root_in_next;
        logic [cap_pkg::QM_W-1:0] rad_in_next;
        logic [cap_pkg::QT_W-1:0] tq_in_next;
        logic ap_in_next, ms_in_next, ts_in_next;
        logic [cap_pkg::SR_W+1:0] acc_next, trial_next, diff_next;
        logic bit_next;

        if (j == 0) begin : g_first
            assign rin_next     = '0;
            assign root_in_next = '0;
            assign rad_in_next  = mq_reg[cap_pkg::QM_W];
            assign tq_in_next   = tq_reg[cap_pkg::QM_W];
            assign ap_in_next   = ap_reg[cap_pkg::QM_W];
            assign ms_in_next   = ms_reg[cap_pkg::QM_W];
            assign ts_in_next   = ts_reg[cap_pkg::QM_W];
        end else begin : g_next
            assign rin_next     = sr_reg[j-1];
            assign root_in_next = sroot_reg[j-1];
            assign rad_in_next  = srad_reg[j-1];
            assign tq_in_next   = stq_reg[j-1];
            assign ap_in_next   = sap_reg[j-1];
            assign ms_in_next   = sms_reg[j-1];
            assign ts_in_next   = sts_reg[j-1];
        end

        assign acc_next   = {rin_next, rad_in_next[cap_pkg::QM_W-1:cap_pkg::QM_W-2]};
        assign trial_next = {2'b00, root_in_next, 2'b01};
        assign diff_next  = acc_next - trial_next;
        assign bit_next   = acc_next >= trial_next;

        always_ff @(posedge aclk) begin
            if (en) begin
                sr_reg[j]    <= bit_next ? diff_next[cap_pkg::SR_W-1:0]
                                         : acc_next[cap_pkg::SR_W-1:0];
                sroot_reg[j] <= {root_in_next[cap_pkg::QR_W-2:0], bit_next};
                srad_reg[j]  <= {rad_in_next[cap_pkg::QM_W-3:0], 2'b00};
                stq_reg[j]   <= tq_in_next;
                sap_reg[j]   <= ap_in_next;
                sms_reg[j]   <= ms_in_next;
                sts_reg[j]   <= ts_in_next;
            end
        end
    end

    always_comb begin
        res_next = '0;
        res_next[0] = sap_reg[cap_pkg::QR_W-1];
        res_next[cap_pkg::OUT_W:1] =
            (!sap_reg[cap_pkg::QR_W-1] || sms_reg[cap_pkg::QR_W-1])
            ? cap_pkg::SAT_VAL : sroot_reg[cap_pkg::QR_W-1];
        res_next[2*cap_pkg::OUT_W:cap_pkg::OUT_W+1] =
            (!sap_reg[cap_pkg::QR_W-1] || sts_reg[cap_pkg::QR_W-1])
            ? cap_pkg::SAT_VAL : stq_reg[cap_pkg::QR_W-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (!out_vld_reg || m_tready) begin
            if (skid_vld_reg) begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                out_vld_reg <= vld_reg[cap_pkg::NST-1];
            end
        end else if (vld_reg[cap_pkg::NST-1]) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_vld_reg || m_tready) begin
            out_reg <= skid_vld_reg ? skid_reg : res_next;
        end else if (en) begin
            skid_reg <= res_next;
        end
    end

endmodule

// ===== src/cap_checker.sv =====
module cap_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [cap_pkg::M_DW-1:0]  m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Stalled result changed.");

    a_never: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[2*cap_pkg::OUT_W:1] == '1)
        else $error("Receding result without saturated outputs.");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[cap_pkg::M_DW-1])
        else $error("Pad bit set.");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |=> s_tready)
        else $error("Input held while output was empty.");

endmodule

bind closest_approach_predictor cap_checker u_cap_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int FRAC_BITS = cap_pkg::FRAC_BITS;
    localparam int IN_W      = cap_pkg::IN_W;
    localparam int D_W       = cap_pkg::D_W;
    localparam int DOT_W     = cap_pkg::DOT_W;
    localparam int VV_W      = cap_pkg::VV_W;
    localparam int C_W       = cap_pkg::C_W;
    localparam int CSQ_W     = cap_pkg::CSQ_W;
    localparam int OUT_W     = cap_pkg::OUT_W;
    localparam int S_DW      = cap_pkg::S_DW;
    localparam int M_DW      = cap_pkg::M_DW;
    localparam logic [OUT_W-1:0] SAT_VAL = cap_pkg::SAT_VAL;

    typedef struct packed {
        logic             approaching;
        logic [OUT_W-1:0] miss_distance;
        logic [OUT_W-1:0] time_to_closest;
    } cpa_result_t;

    typedef struct {
        logic signed [IN_W-1:0] own[3];
        logic signed [IN_W-1:0] oth[3];
        logic signed [IN_W-1:0] vel[3];
        logic                   has_fixed;
        cpa_result_t            fixed;
    } pair_row_t;

    localparam int N_RANDOM   = 1430;
    localparam int WATCH_LIMIT = 5000;
    localparam logic signed [IN_W-1:0] MAXP = 32'sh7fffffff;
    localparam logic signed [IN_W-1:0] MINP = 32'sh80000000;
    localparam logic signed [IN_W-1:0] ONE  = 32'sh00010000;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [S_DW-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [M_DW-1:0]  m_tdata;

    cpa_result_t      expected_q[$];
    pair_row_t        rows[$];
    int               n_errors = 0;
    int               idle_cycles = 0;
    bit               stim_done = 1'b0;

    always #2 aclk = ~aclk;

    closest_approach_predictor i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    function automatic cpa_result_t predict_approach(pair_row_t r);
        cpa_result_t res;
        logic signed [D_W-1:0]    d[3];
        logic signed [D_W-1:0]    v[3];
        logic signed [DOT_W+1:0]  dot;
        logic [VV_W+1:0]          vv;
        logic signed [C_W+1:0]    c[3];
        logic [CSQ_W+3:0]         csq;
        logic [CSQ_W+3:0]         tgt;
        logic [CSQ_W+3:0]         trial;
        logic [OUT_W-1:0]         m;
        logic [OUT_W-1:0]         t;
        logic [OUT_W-1:0]         cand;
        for (int i = 0; i < 3; i++) begin
            d[i] = D_W'(r.oth[i]) - D_W'(r.own[i]);
            v[i] = D_W'(r.vel[i]);
        end
        dot = 0;
        vv = 0;
        for (int i = 0; i < 3; i++) begin
            dot += d[i] * v[i];
            vv += (VV_W+2)'(v[i] * v[i]);
        end
        res.approaching = 1'b0;
        res.miss_distance = SAT_VAL;
        res.time_to_closest = SAT_VAL;
        if (dot <= 0 || vv == 0) begin
            return res;
        end
        c[0] = d[1] * v[2] - d[2] * v[1];
        c[1] = d[2] * v[0] - d[0] * v[2];
        c[2] = d[0] * v[1] - d[1] * v[0];
        csq = 0;
        for (int i = 0; i < 3; i++) begin
            csq += (CSQ_W+4)'(c[i] * c[i]);
        end
        tgt = (CSQ_W+4)'(dot) << FRAC_BITS;
        m = 0;
        t = 0;
        for (int b = OUT_W - 1; b >= 0; b--) begin
            cand = m | (OUT_W'(1) << b);
            trial = (CSQ_W+4)'(cand) * cand * vv;
            if (trial <= csq) begin
                m = cand;
            end
            cand = t | (OUT_W'(1) << b);
            trial = (CSQ_W+4)'(cand) * vv;
            if (trial <= tgt) begin
                t = cand;
            end
        end
        res.approaching = 1'b1;
        res.miss_distance = m;
        res.time_to_closest = t;
        return res;
    endfunction

    function automatic logic signed [IN_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return MAXP;
            1: return MINP;
            2: return $urandom;
            3, 4: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
            default: return $signed($urandom_range(0, 32'h0fffffff)) - 32'sh08000000;
        endcase
    endfunction

    function automatic pair_row_t make_row(logic signed [IN_W-1:0] a[3],
                                           logic signed [IN_W-1:0] b[3],
                                           logic signed [IN_W-1:0] v[3]);
        pair_row_t r;
        r.own = a;
        r.oth = b;
        r.vel = v;
        r.has_fixed = 1'b0;
        r.fixed = '0;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [OUT_W-1:0] got,
                                   logic [OUT_W-1:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        n_errors++;
    endtask

    task automatic send_pair(pair_row_t r);
        s_tdata <= {r.vel[2], r.vel[1], r.vel[0], r.oth[2], r.oth[1], r.oth[0],
                    r.own[2], r.own[1], r.own[0]};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        expected_q.push_back(r.has_fixed ? r.fixed : predict_approach(r));
    endtask

    task automatic build_directed();
        logic signed [IN_W-1:0] z[3] = '{0, 0, 0};
        logic signed [IN_W-1:0] mx[3] = '{MAXP, MAXP, MAXP};
        logic signed [IN_W-1:0] mn[3] = '{MINP, MINP, MINP};
        logic signed [IN_W-1:0] ex[3] = '{ONE, 0, 0};
        logic signed [IN_W-1:0] fwd[3] = '{ONE * 4, ONE, 0};
        logic signed [IN_W-1:0] back[3] = '{-ONE * 4, ONE, 0};
        logic signed [IN_W-1:0] abeam[3] = '{0, ONE * 3, 0};
        logic signed [IN_W-1:0] tiny[3] = '{1, 0, 0};
        pair_row_t r;
        r = make_row(z, z, z);
        r.has_fixed = 1'b1;
        r.fixed = '{1'b0, SAT_VAL, SAT_VAL};
        rows.push_back(r);
        r = make_row(z, fwd, z);
        r.has_fixed = 1'b1;
        r.fixed = '{1'b0, SAT_VAL, SAT_VAL};
        rows.push_back(r);
        r = make_row(z, back, ex);
        r.has_fixed = 1'b1;
        r.fixed = '{1'b0, SAT_VAL, SAT_VAL};
        rows.push_back(r);
        r = make_row(z, abeam, ex);
        r.has_fixed = 1'b1;
        r.fixed = '{1'b0, SAT_VAL, SAT_VAL};
        rows.push_back(r);
        r = make_row(z, fwd, ex);
        r.has_fixed = 1'b1;
        r.fixed = '{1'b1, OUT_W'(ONE), OUT_W'(ONE * 4)};
        rows.push_back(r);
        rows.push_back(make_row(z, fwd, tiny));
        rows.push_back(make_row(mn, mx, mx));
        rows.push_back(make_row(mx, mn, mn));
        rows.push_back(make_row(mn, mx, mn));
        rows.push_back(make_row(mx, mn, mx));
        rows.push_back(make_row(mn, mx, tiny));
        rows.push_back(make_row(z, mx, mx));
        rows.push_back(make_row(z, mn, mn));
        rows.push_back(make_row(mx, mx, mx));
        rows.push_back(make_row(mn, z, ex));
        rows.push_back(make_row(z, tiny, mx));
        rows.push_back(make_row(z, '{MAXP, 0, 0}, '{1, MAXP, MINP}));
        rows.push_back(make_row(z, ex, '{-1, -1, -1}));
        rows.push_back(make_row(fwd, z, back));
    endtask

    initial begin
        pair_row_t r;
        int burst;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        build_directed();
        for (int i = 0; i < N_RANDOM; i++) begin
            for (int k = 0; k < 3; k++) begin
                r.own[k] = rand_coord();
                r.oth[k] = rand_coord();
                r.vel[k] = rand_coord();
            end
            if ($urandom_range(0, 3) == 0) begin
                r.vel = '{$signed($urandom_range(0, 6)) - 3, 0, 0};
            end
            r.has_fixed = 1'b0;
            rows.push_back(r);
        end
        burst = 0;
        foreach (rows[i]) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 40);
                if ($urandom_range(0, 1) == 1) begin
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge aclk);
                end
            end
            send_pair(rows[i]);
            burst--;
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    always @(posedge aclk) begin
        int phase;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            phase = ($time / 4) % 300;
            if (phase < 60) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    always @(posedge aclk) begin
        cpa_result_t got;
        cpa_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.approaching = m_tdata[0];
            got.miss_distance = m_tdata[OUT_W:1];
            got.time_to_closest = m_tdata[2*OUT_W:OUT_W+1];
            if (expected_q.size() == 0) begin
                $display("unexpected result transfer at %0t", $time);
                n_errors++;
            end else begin
                want = expected_q.pop_front();
                if (got.approaching != want.approaching) begin
                    report_mismatch("approaching", OUT_W'(got.approaching),
                                    OUT_W'(want.approaching));
                end
                if (got.miss_distance != want.miss_distance) begin
                    report_mismatch("miss_distance", got.miss_distance, want.miss_distance);
                end
                if (got.time_to_closest != want.time_to_closest) begin
                    report_mismatch("time_to_closest", got.time_to_closest,
                                    want.time_to_closest);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        @(posedge aresetn);
        while (!(stim_done && expected_q.size() == 0) && idle_cycles < WATCH_LIMIT) begin
            @(posedge aclk);
        end
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("timeout: %0d results outstanding", expected_q.size());
            $display("** closest_approach_predictor: FAILED **");
        end else begin
            repeat (120) @(posedge aclk);
            if (n_errors == 0 && expected_q.size() == 0) begin
                $display("** closest_approach_predictor: PASSED **");
            end else begin
                $display("** closest_approach_predictor: FAILED **");
            end
        end
        $finish;
    end
endmodule
